FILE: src/pch_pkg.sv
// shared types and constants of the pair co-occurrence histogram
`default_nettype none

package pch_pkg;

    localparam int VALUE_W = 7;
    localparam int QUEUE_DEPTH = 4;

    typedef struct packed {
        logic is_read;
        logic ok;
    } pch_cmd_t;

    localparam int CMD_W = $bits(pch_cmd_t);

endpackage

`default_nettype wire

FILE: src/pch_front.sv
// front end: accepts beats, removes duplicate values and issues one command per pair
`default_nettype none

module pch_front
    import pch_pkg::*;
#(
    parameter int NUM_VALUES = 64,
    parameter int SET_SIZE = 5,
    parameter int ADDR_W = 11
)
(
    input  wire logic                             clk,
    input  wire logic                             rst_n,
    input  wire logic                             in_valid,
    output logic                                  in_ready,
    input  wire logic                             kind,
    input  wire logic [SET_SIZE-1:0][VALUE_W-1:0] values,
    input  wire logic [VALUE_W-1:0]               query_larger,
    input  wire logic [VALUE_W-1:0]               query_smaller,
    input  wire logic                             clearing,
    output logic                                  push_valid,
    input  wire logic                             push_ready,
    output logic [ADDR_W-1:0]                     push_addr,
    output pch_cmd_t                              push_cmd
);

    localparam int CNT_W = $clog2(SET_SIZE);
    localparam int PROD_W = 2 * VALUE_W;
    localparam logic [CNT_W-1:0] CNT_FIRST = CNT_W'(SET_SIZE - 1);
    localparam logic [CNT_W-1:0] CNT_ONE = CNT_W'(1);

    typedef enum logic {
        ST_IDLE,
        ST_PAIRS
    } state_t;

    state_t               state_reg, state_next;
    logic [VALUE_W-1:0]   a_val_reg [SET_SIZE];
    logic [VALUE_W-1:0]   a_val_next [SET_SIZE];
    logic [VALUE_W-1:0]   b_val_reg [SET_SIZE];
    logic [VALUE_W-1:0]   b_val_next [SET_SIZE];
    logic [SET_SIZE-1:0]  a_keep_reg, a_keep_next;
    logic [SET_SIZE-1:0]  b_keep_reg, b_keep_next;
    logic [CNT_W-1:0]     rem_reg, rem_next;
    logic [CNT_W-1:0]     reload_reg, reload_next;

    logic [SET_SIZE-1:0]  keep_in;
    logic                 accept;
    logic                 pair_hit;
    logic                 step;
    logic                 read_ok;
    logic [VALUE_W-1:0]   x_val;
    logic [VALUE_W-1:0]   y_val;
    logic [VALUE_W-1:0]   lo_val;
    logic [VALUE_W-1:0]   hi_val;
    logic [PROD_W-1:0]    hm1;
    logic [PROD_W-1:0]    hm2;
    logic [PROD_W-1:0]    prod;
    logic [PROD_W-1:0]    slot;

    function automatic logic in_range(input logic [VALUE_W-1:0] v);
        return (v != '0) && (int'(v) <= NUM_VALUES);
    endfunction

    // first in-range occurrence of each value
    always_comb
    begin
        for (int k = 0; k < SET_SIZE; k++)
        begin
            keep_in[k] = in_range(values[k]);
            for (int j = 0; j < k; j++)
            begin
                if (values[j] == values[k])
                begin
                    keep_in[k] = 1'b0;
                end
            end
        end
    end

    assign in_ready = (state_reg == ST_IDLE) && !clearing && push_ready;
    assign accept   = in_valid && in_ready;
    assign pair_hit = a_keep_reg[0] && b_keep_reg[0];
    assign step     = !pair_hit || push_ready;
    assign read_ok  = in_range(query_larger) && in_range(query_smaller)
                      && (query_smaller < query_larger);

    // pair to table slot: (hi-1)(hi-2)/2 + (lo-1)
    always_comb
    begin
        x_val  = (state_reg == ST_IDLE) ? query_larger : a_val_reg[0];
        y_val  = (state_reg == ST_IDLE) ? query_smaller : b_val_reg[0];
        lo_val = (x_val < y_val) ? x_val : y_val;
        hi_val = (x_val < y_val) ? y_val : x_val;
        hm1    = PROD_W'(hi_val - VALUE_W'(1));
        hm2    = PROD_W'(hi_val - VALUE_W'(2));
        prod   = hm1 * hm2;
        slot   = (prod >> 1) + PROD_W'(lo_val - VALUE_W'(1));
    end

    assign push_addr = ADDR_W'(slot);

    always_comb
    begin
        if (state_reg == ST_IDLE)
        begin
            push_valid       = in_valid && !clearing && kind;
            push_cmd.is_read = 1'b1;
            push_cmd.ok      = read_ok;
        end
        else
        begin
            push_valid       = pair_hit;
            push_cmd.is_read = 1'b0;
            push_cmd.ok      = 1'b1;
        end
    end

    always_comb
    begin
        state_next  = state_reg;
        a_val_next  = a_val_reg;
        b_val_next  = b_val_reg;
        a_keep_next = a_keep_reg;
        b_keep_next = b_keep_reg;
        rem_next    = rem_reg;
        reload_next = reload_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept && !kind)
                begin
                    for (int k = 0; k < SET_SIZE; k++)
                    begin
                        a_val_next[k]  = values[k];
                        a_keep_next[k] = keep_in[k];
                        if (k + 1 < SET_SIZE)
                        begin
                            b_val_next[k]  = values[k + 1];
                            b_keep_next[k] = keep_in[k + 1];
                        end
                        else
                        begin
                            b_val_next[k]  = '0;
                            b_keep_next[k] = 1'b0;
                        end
                    end
                    rem_next    = CNT_FIRST;
                    reload_next = CNT_FIRST;
                    state_next  = ST_PAIRS;
                end
            end
            ST_PAIRS:
            begin
                if (step)
                begin
                    if (rem_reg == CNT_ONE)
                    begin
                        if (reload_reg == CNT_ONE)
                        begin
                            state_next = ST_IDLE;
                        end
                        else
                        begin
                            // next anchor, partner list restarts right after it
                            for (int k = 0; k < SET_SIZE; k++)
                            begin
                                if (k + 1 < SET_SIZE)
                                begin
                                    a_val_next[k]  = a_val_reg[k + 1];
                                    a_keep_next[k] = a_keep_reg[k + 1];
                                end
                                else
                                begin
                                    a_val_next[k]  = '0;
                                    a_keep_next[k] = 1'b0;
                                end
                                if (k + 2 < SET_SIZE)
                                begin
                                    b_val_next[k]  = a_val_reg[k + 2];
                                    b_keep_next[k] = a_keep_reg[k + 2];
                                end
                                else
                                begin
                                    b_val_next[k]  = '0;
                                    b_keep_next[k] = 1'b0;
                                end
                            end
                            reload_next = reload_reg - CNT_ONE;
                            rem_next    = reload_reg - CNT_ONE;
                        end
                    end
                    else
                    begin
                        for (int k = 0; k < SET_SIZE; k++)
                        begin
                            if (k + 1 < SET_SIZE)
                            begin
                                b_val_next[k]  = b_val_reg[k + 1];
                                b_keep_next[k] = b_keep_reg[k + 1];
                            end
                            else
                            begin
                                b_val_next[k]  = '0;
                                b_keep_next[k] = 1'b0;
                            end
                        end
                        rem_next = rem_reg - CNT_ONE;
                    end
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= ST_IDLE;
            a_keep_reg <= '0;
            b_keep_reg <= '0;
            rem_reg    <= '0;
            reload_reg <= '0;
            for (int k = 0; k < SET_SIZE; k++)
            begin
                a_val_reg[k] <= '0;
                b_val_reg[k] <= '0;
            end
        end
        else
        begin
            state_reg  <= state_next;
            a_keep_reg <= a_keep_next;
            b_keep_reg <= b_keep_next;
            rem_reg    <= rem_next;
            reload_reg <= reload_next;
            a_val_reg  <= a_val_next;
            b_val_reg  <= b_val_next;
        end
    end

endmodule

`default_nettype wire

FILE: src/pch_queue.sv
// short command queue between front end and counter back end
`default_nettype none

module pch_queue #(
    parameter int DATA_W = 13,
    parameter int DEPTH = 4
)
(
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [DATA_W-1:0] in_data,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [DATA_W-1:0]      out_data
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [CNT_W-1:0] FULL = CNT_W'(DEPTH);
    localparam logic [PTR_W-1:0] LAST = PTR_W'(DEPTH - 1);

    logic [DATA_W-1:0] slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    logic              push;
    logic              pop;

    assign in_ready  = (count_reg != FULL);
    assign out_valid = (count_reg != '0);
    assign out_data  = slot_reg[rd_ptr_reg];
    assign push      = in_valid && in_ready;
    assign pop       = out_valid && out_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == LAST) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == LAST) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slot_reg[wr_ptr_reg] <= in_data;
        end
    end

endmodule

`default_nettype wire

FILE: src/pch_back.sv
// back end: counter memory with clearing pass, read-modify-write pipe and result register
`default_nettype none

module pch_back
    import pch_pkg::*;
#(
    parameter int NUM_VALUES = 64,
    parameter int COUNT_WIDTH = 16,
    parameter int ADDR_W = 11
)
(
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    input  wire logic                   pop_valid,
    output logic                        pop_ready,
    input  wire logic [ADDR_W-1:0]      pop_addr,
    input  wire pch_cmd_t               pop_cmd,
    output logic                        clearing,
    output logic                        out_valid,
    input  wire logic                   out_ready,
    output logic [COUNT_WIDTH-1:0]      out_count,
    output logic                        out_pair_valid
);

    localparam int PAIR_DEPTH = NUM_VALUES * (NUM_VALUES - 1) / 2;
    localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(PAIR_DEPTH - 1);

    logic [COUNT_WIDTH-1:0] count_mem [PAIR_DEPTH];

    logic                   clr_busy_reg;
    logic [ADDR_W-1:0]      clr_addr_reg;
    logic                   b_valid_reg, b_valid_next;
    pch_cmd_t               b_cmd_reg;
    logic [ADDR_W-1:0]      b_addr_reg;
    logic                   fwd_hit_reg;
    logic [COUNT_WIDTH-1:0] fwd_data_reg;
    logic [COUNT_WIDTH-1:0] rdata_reg;
    logic                   out_valid_reg;
    logic [COUNT_WIDTH-1:0] out_count_reg;
    logic                   out_ok_reg;

    logic [COUNT_WIDTH-1:0] b_cur;
    logic [COUNT_WIDTH-1:0] b_inc;
    logic                   b_wr;
    logic                   b_adv;
    logic                   a_fire;
    logic                   wr_en;
    logic [ADDR_W-1:0]      wr_addr;
    logic [COUNT_WIDTH-1:0] wr_data;

    // a read issued while the previous bump writes the same counter takes the new value
    assign b_cur = fwd_hit_reg ? fwd_data_reg : rdata_reg;
    assign b_inc = (&b_cur) ? b_cur : b_cur + COUNT_WIDTH'(1);
    assign b_wr  = b_valid_reg && !b_cmd_reg.is_read;
    assign b_adv = b_valid_reg && (!b_cmd_reg.is_read || !out_valid_reg || out_ready);

    assign pop_ready = !clr_busy_reg && (!b_valid_reg || b_adv);
    assign a_fire    = pop_valid && pop_ready;

    assign wr_en   = clr_busy_reg || b_wr;
    assign wr_addr = clr_busy_reg ? clr_addr_reg : b_addr_reg;
    assign wr_data = clr_busy_reg ? '0 : b_inc;

    assign b_valid_next = a_fire || (b_valid_reg && !b_adv);

    assign clearing       = clr_busy_reg;
    assign out_valid      = out_valid_reg;
    assign out_count      = out_count_reg;
    assign out_pair_valid = out_ok_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            count_mem[wr_addr] <= wr_data;
        end
        if (a_fire)
        begin
            rdata_reg <= count_mem[pop_addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            clr_busy_reg  <= 1'b1;
            clr_addr_reg  <= '0;
            b_valid_reg   <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (clr_busy_reg)
            begin
                clr_addr_reg <= clr_addr_reg + ADDR_W'(1);
                if (clr_addr_reg == LAST_ADDR)
                begin
                    clr_busy_reg <= 1'b0;
                end
            end
            b_valid_reg <= b_valid_next;
            if (b_adv && b_cmd_reg.is_read)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (out_ready)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (a_fire)
        begin
            b_cmd_reg    <= pop_cmd;
            b_addr_reg   <= pop_addr;
            fwd_hit_reg  <= b_wr && (b_addr_reg == pop_addr);
            fwd_data_reg <= b_inc;
        end
        if (b_adv && b_cmd_reg.is_read)
        begin
            out_count_reg <= b_cmd_reg.ok ? b_cur : '0;
            out_ok_reg    <= b_cmd_reg.ok;
        end
    end

`ifndef SYNTHESIS
    assert property (@(posedge clk) disable iff (!rst_n)
        clr_busy_reg |-> !b_valid_reg)
        else $error("counter pipe busy during clearing pass");

    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg && !out_ok_reg |-> out_count_reg == '0)
        else $error("invalid pair returned a nonzero count");

    assert property (@(posedge clk) disable iff (!rst_n)
        b_valid_reg && b_cmd_reg.is_read && !b_adv |-> out_valid_reg && !out_ready)
        else $error("read held back while result register free");
`endif

endmodule

`default_nettype wire

FILE: src/pair_cooccurrence_histogram_unit.sv
// top level of the pair co-occurrence histogram
`default_nettype none

// Counts how often two distinct values from 1 to NUM_VALUES show up together in an added
// set of SET_SIZE values, one saturating COUNT_WIDTH-bit counter per unordered pair, and
// answers reads of single pair counters. After an add beat (kind 0) is accepted the front
// end walks its SET_SIZE*(SET_SIZE-1)/2 candidate pairs, 10 by default, one per cycle, with
// s_tready low, so no new add beat is taken until the walk is done; each real pair is one
// read-modify-write of the counter memory, which has one write port, and the walk pauses
// while the command queue is full. A read beat (kind 1) is taken when the queue has room;
// its result beat passes the command queue, the back end's read stage and the result
// register before it shows on m_tvalid. Only reads give a result beat, and a result held
// back by m_tready stalls the next read, so the queue can fill and then hold s_tready low.
// After reset a clearing pass writes zero to all NUM_VALUES*(NUM_VALUES-1)/2 counters,
// 2016 by default, with s_tready low.
// Values are 7 bits wide, so at most 127 distinct values can be used.
module pair_cooccurrence_histogram_unit
    import pch_pkg::*;
#(
    parameter int NUM_VALUES = 64,
    parameter int SET_SIZE = 5,
    parameter int COUNT_WIDTH = 16
)
(
    input  wire logic                 clk,
    input  wire logic                 rst_n,
    input  wire logic                 s_tvalid,
    output logic                      s_tready,
    // value_0 .. value_(SET_SIZE-1), query_larger, query_smaller, zero pad
    input  wire logic [((SET_SIZE + 2) * VALUE_W + 7) / 8 * 8 - 1:0] s_tdata,
    // kind
    input  wire logic                 s_tuser,
    output logic                      m_tvalid,
    input  wire logic                 m_tready,
    // pair_count, zero pad
    output logic [(COUNT_WIDTH + 7) / 8 * 8 - 1:0] m_tdata,
    // pair_valid
    output logic                      m_tuser
);

    localparam int PAIR_DEPTH = NUM_VALUES * (NUM_VALUES - 1) / 2;
    localparam int ADDR_W = (PAIR_DEPTH > 1) ? $clog2(PAIR_DEPTH) : 1;
    localparam int M_TDATA_W = (COUNT_WIDTH + 7) / 8 * 8;
    localparam int Q_DATA_W = ADDR_W + CMD_W;

    logic [SET_SIZE-1:0][VALUE_W-1:0] values;
    logic [VALUE_W-1:0]               query_larger;
    logic [VALUE_W-1:0]               query_smaller;

    logic                  clearing;
    logic                  push_valid;
    logic                  push_ready;
    logic [ADDR_W-1:0]     push_addr;
    pch_cmd_t              push_cmd;
    logic                  pop_valid;
    logic                  pop_ready;
    logic [Q_DATA_W-1:0]   pop_data;
    logic [ADDR_W-1:0]     pop_addr;
    pch_cmd_t              pop_cmd;
    logic [COUNT_WIDTH-1:0] out_count;

    always_comb
    begin
        for (int k = 0; k < SET_SIZE; k++)
        begin
            values[k] = s_tdata[k * VALUE_W +: VALUE_W];
        end
    end

    assign query_larger  = s_tdata[SET_SIZE * VALUE_W +: VALUE_W];
    assign query_smaller = s_tdata[(SET_SIZE + 1) * VALUE_W +: VALUE_W];

    pch_front #(
        .NUM_VALUES (NUM_VALUES),
        .SET_SIZE   (SET_SIZE),
        .ADDR_W     (ADDR_W)
    ) u_front (
        .clk           (clk),
        .rst_n         (rst_n),
        .in_valid      (s_tvalid),
        .in_ready      (s_tready),
        .kind          (s_tuser),
        .values        (values),
        .query_larger  (query_larger),
        .query_smaller (query_smaller),
        .clearing      (clearing),
        .push_valid    (push_valid),
        .push_ready    (push_ready),
        .push_addr     (push_addr),
        .push_cmd      (push_cmd)
    );

    pch_queue #(
        .DATA_W (Q_DATA_W),
        .DEPTH  (QUEUE_DEPTH)
    ) u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (push_valid),
        .in_ready  (push_ready),
        .in_data   ({push_addr, push_cmd}),
        .out_valid (pop_valid),
        .out_ready (pop_ready),
        .out_data  (pop_data)
    );

    assign pop_addr = pop_data[Q_DATA_W-1:CMD_W];
    assign pop_cmd  = pch_cmd_t'(pop_data[CMD_W-1:0]);

    pch_back #(
        .NUM_VALUES  (NUM_VALUES),
        .COUNT_WIDTH (COUNT_WIDTH),
        .ADDR_W      (ADDR_W)
    ) u_back (
        .clk            (clk),
        .rst_n          (rst_n),
        .pop_valid      (pop_valid),
        .pop_ready      (pop_ready),
        .pop_addr       (pop_addr),
        .pop_cmd        (pop_cmd),
        .clearing       (clearing),
        .out_valid      (m_tvalid),
        .out_ready      (m_tready),
        .out_count      (out_count),
        .out_pair_valid (m_tuser)
    );

    assign m_tdata = M_TDATA_W'(out_count);

endmodule

`default_nettype wire
